### rtl/weighted_distance_gradient_hessian_top_defines.svh
// Assertion macros shared by the distance gradient and Hessian RTL.
// Depends on nothing; the including module provides clock and reset.
`ifndef WEIGHTED_DISTANCE_GRADIENT_HESSIAN_TOP_DEFINES_SVH
`define WEIGHTED_DISTANCE_GRADIENT_HESSIAN_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WDGH_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication with a fixed delay in cycles.
`define WDGH_ASSERT_DLY(label, ante, dly, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

### rtl/wdgh_pkg.sv
// Package for the weighted distance gradient and Hessian block.
// Holds default parameter values, fixed widths and the sign bundle type.
package wdgh_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int COORD_WIDTH_DEF = 32;
   // Differences are scaled down until both fit in this many bits for the Hessian.
   localparam int NORM_BITS       = 31;

   typedef struct packed {
      logic wn;
      logic xn;
      logic yn;
      logic coin;
   } sign_type;

endpackage

### rtl/wdgh_div.sv
// Pipelined restoring divider: one quotient bit per stage.
// Stand-alone; reports when the quotient does not fit in QB bits.
module wdgh_div #(
   parameter int NW = 64,
   parameter int DW = 32,
   parameter int QB = 32
) (
   input  logic          clock,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QB-1:0] quo,
   output logic          ovf
);

   localparam int HW = NW - QB;
   localparam int XW = (HW > DW) ? HW : DW;

   logic [DW-1:0] rem_ff [QB+1];
   logic [QB-1:0] lo_ff  [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic [DW-1:0] den_ff [QB+1];
   logic          ovf_ff [QB+1];

   logic [DW:0]   part_w [1:QB];
   logic [DW-1:0] rem_in [1:QB];
   logic [QB-1:0] q_in   [1:QB];

   always_comb begin
      for (int i = 1; i <= QB; i++) begin
         part_w[i] = {rem_ff[i-1], lo_ff[i-1][QB-1]};
         if (part_w[i] >= {1'b0, den_ff[i-1]}) begin
            rem_in[i] = DW'(part_w[i] - {1'b0, den_ff[i-1]});
            q_in[i]   = {q_ff[i-1][QB-2:0], 1'b1};
         end else begin
            rem_in[i] = part_w[i][DW-1:0];
            q_in[i]   = {q_ff[i-1][QB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      // The high part of the numerator is the starting remainder; when it is not
      // below the divisor the quotient overflows and the bits below are meaningless.
      rem_ff[0] <= DW'(num[NW-1:QB]);
      lo_ff[0]  <= num[QB-1:0];
      q_ff[0]   <= '0;
      den_ff[0] <= den;
      ovf_ff[0] <= XW'(num[NW-1:QB]) >= XW'(den);
      for (int i = 1; i <= QB; i++) begin
         rem_ff[i] <= rem_in[i];
         lo_ff[i]  <= {lo_ff[i-1][QB-2:0], 1'b0};
         q_ff[i]   <= q_in[i];
         den_ff[i] <= den_ff[i-1];
         ovf_ff[i] <= ovf_ff[i-1];
      end
   end

   assign quo = q_ff[QB];
   assign ovf = ovf_ff[QB];

endmodule

### rtl/wdgh_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Stand-alone; gives the floor of the square root of a 2*RW bit value.
module wdgh_sqrt #(
   parameter int RW = 33
) (
   input  logic            clock,
   input  logic [2*RW-1:0] radicand,
   output logic [RW-1:0]   root
);

   localparam int SW = 2 * RW;

   logic [RW+1:0] rem_ff  [RW+1];
   logic [RW-1:0] root_ff [RW+1];
   logic [SW-1:0] rest_ff [RW+1];

   logic [RW+1:0] part_w  [1:RW];
   logic [RW+1:0] trial_w [1:RW];
   logic [RW+1:0] rem_in  [1:RW];
   logic [RW-1:0] root_in [1:RW];

   always_comb begin
      for (int i = 1; i <= RW; i++) begin
         part_w[i]  = {rem_ff[i-1][RW-1:0], rest_ff[i-1][SW-1:SW-2]};
         trial_w[i] = {root_ff[i-1], 2'b01};
         if (part_w[i] >= trial_w[i]) begin
            rem_in[i]  = part_w[i] - trial_w[i];
            root_in[i] = {root_ff[i-1][RW-2:0], 1'b1};
         end else begin
            rem_in[i]  = part_w[i];
            root_in[i] = {root_ff[i-1][RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      rest_ff[0] <= radicand;
      for (int i = 1; i <= RW; i++) begin
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
         rest_ff[i] <= {rest_ff[i-1][SW-3:0], 2'b00};
      end
   end

   assign root = root_ff[RW];

endmodule

### rtl/weighted_distance_gradient_hessian_top.sv
// Weighted Euclidean distance with gradient and Hessian terms, fixed point.
// Uses wdgh_pkg, wdgh_div, wdgh_sqrt and the assertion macro header.
//
// Usage: an item (two points) is taken at a clock edge where start is high and
// busy is low. busy never rises, so one item can be started in every cycle.
// Each result beat appears on the rsp_ ports for one cycle with rsp_valid high;
// results come out in start order, one per item. The receiver cannot stall, so
// no beat waits. Two bit-serial pipelines are chained: the square root and the
// first Hessian divisions (one quotient bit per stage) run side by side, then
// the gradient and final Hessian divisions (one bit per stage) follow.
// The weight is written through the csr_ channel (csr_ready is always high)
// and should only change while no item is in flight.
// Reset clears the valid pipeline and sets the weight to 1.0; items in flight
// are dropped. Coincident points give zero terms with rsp_coincident high, and
// any result clipped to the signed range raises rsp_saturated.
`include "weighted_distance_gradient_hessian_top_defines.svh"

module weighted_distance_gradient_hessian_top
   import wdgh_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic signed [COORD_WIDTH-1:0] csr_wdata,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_cost_value,
   output logic signed [COORD_WIDTH-1:0] rsp_grad_x,
   output logic signed [COORD_WIDTH-1:0] rsp_grad_y,
   output logic signed [COORD_WIDTH-1:0] rsp_hess_xx,
   output logic signed [COORD_WIDTH-1:0] rsp_hess_yy,
   output logic signed [COORD_WIDTH-1:0] rsp_hess_xy,
   output logic                          rsp_coincident,
   output logic                          rsp_saturated
);

   localparam int W      = COORD_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int MW     = W + 1;
   localparam int SW     = 2 * MW;
   localparam int KW     = $clog2(MW + 1);
   localparam int AW     = NORM_BITS;
   localparam int PW     = 2 * AW;
   localparam int GNW    = W + MW;
   localparam int NQW    = W + PW;
   localparam int HNW    = W + F;
   localparam int CW     = W + MW;
   localparam int LAT    = 2 * W + 11;
   localparam int GN_DLY = W + 4;
   localparam int UW_DLY = W + 1;
   localparam int FL_DLY = 2 * W + 2;
   localparam int CP_DLY = W + 1;

   localparam logic [W-1:0]  W_RESET = W'(1) << F;
   localparam logic [CW-1:0] LIM_NEG = CW'(1) << (W - 1);
   localparam logic [CW-1:0] LIM_POS = LIM_NEG - CW'(1);

   function automatic logic [W:0] clip_fn(input logic [CW-1:0] m, input logic neg,
                                          input logic big);
      logic [CW-1:0] lim;
      logic          s;
      logic [W-1:0]  v;
      lim = neg ? LIM_NEG : LIM_POS;
      s   = big || (m > lim);
      v   = s ? lim[W-1:0] : m[W-1:0];
      if (neg) begin
         v = -v;
      end
      return {s, v};
   endfunction

   logic           accept_w;
   logic [W-1:0]   weight_ff;
   logic [LAT-1:0] vld_ff;

   // Stage 1: differences.
   logic [MW-1:0] dx1_ff, dy1_ff;
   // Stage 2: magnitudes and signs.
   logic [MW-1:0] ux2_ff, uy2_ff;
   logic [W-1:0]  uw2_ff;
   sign_type      sg2_ff;
   // Stage 3: squares and normalizing shift.
   logic [SW-1:0] sqx3_ff, sqy3_ff;
   logic [KW-1:0] k_in, k3_ff;
   logic [MW-1:0] ux3_ff, uy3_ff, m_w;
   logic [W-1:0]  uw3_ff;
   sign_type      sg3_ff;
   // Stage 4: distance squared and scaled differences.
   logic [SW-1:0] ssum4_ff;
   logic [AW-1:0] ax4_ff, ay4_ff;
   logic [MW-1:0] ux4_ff, uy4_ff;
   logic [W-1:0]  uw4_ff;
   sign_type      sg4_ff;
   // Stage 5: scaled products and gradient numerators.
   logic [PW-1:0]  axx5_ff, ayy5_ff, axy5_ff;
   logic [GNW-1:0] gnx5_ff, gny5_ff;
   logic [W-1:0]   uw5_ff;
   sign_type       sg5_ff;
   // Stage 6: scaled distance squared.
   logic [PW:0]    sp6_ff;
   logic [PW-1:0]  axx6_ff, ayy6_ff, axy6_ff;
   logic [W-1:0]   uw6_ff;
   sign_type       sg6_ff;
   // Stage 7: weight times split products.
   logic [W+AW-1:0] plxx7_ff, phxx7_ff, plyy7_ff, phyy7_ff, plxy7_ff, phxy7_ff;
   logic [PW:0]     sp7_ff;
   logic [W-1:0]    uw7_ff;
   sign_type        sg7_ff;
   // Stage 8: Hessian numerators.
   logic [NQW-1:0] nxx8_ff, nyy8_ff, nxy8_ff;
   logic [PW:0]    sp8_ff;
   logic [W-1:0]   uw8_ff;
   sign_type       sg8_ff;

   logic [GNW-1:0] gnx_dly_ff [GN_DLY];
   logic [GNW-1:0] gny_dly_ff [GN_DLY];
   logic [W-1:0]   uw_dly_ff  [UW_DLY];
   sign_type       sg_dly_ff  [FL_DLY];
   logic [MW-1:0]  d_dly_ff   [3];
   logic [CW-1:0]  cp_dly_ff  [CP_DLY];

   logic [MW-1:0] root_w;
   logic [W-1:0]  qxx_w, qyy_w, qxy_w;
   logic [W-1:0]  gqx_w, gqy_w, hxx_w, hyy_w, hxy_w;
   logic          hxx_ovf_w, hyy_ovf_w, hxy_ovf_w, gx_ovf_w, gy_ovf_w;

   logic [W:0]   c_cost_w, c_gx_w, c_gy_w, c_hxx_w, c_hyy_w, c_hxy_w;
   sign_type     sg_end_w;

   logic [W-1:0] rsp_cost_ff, rsp_gx_ff, rsp_gy_ff, rsp_hxx_ff, rsp_hyy_ff, rsp_hxy_ff;
   logic         rsp_coin_ff, rsp_sat_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept_w  = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= W_RESET;
         vld_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            weight_ff <= csr_wdata;
         end
         vld_ff <= {vld_ff[LAT-2:0], accept_w};
      end
   end

   // Leading-one search above the normalized width picks the shift for both axes.
   always_comb begin
      m_w  = ux2_ff | uy2_ff;
      k_in = '0;
      for (int i = AW; i < MW; i++) begin
         if (m_w[i]) begin
            k_in = KW'(i - AW + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      dx1_ff <= {req_first_x[W-1], req_first_x} - {req_second_x[W-1], req_second_x};
      dy1_ff <= {req_first_y[W-1], req_first_y} - {req_second_y[W-1], req_second_y};

      ux2_ff      <= dx1_ff[MW-1] ? -dx1_ff : dx1_ff;
      uy2_ff      <= dy1_ff[MW-1] ? -dy1_ff : dy1_ff;
      uw2_ff      <= weight_ff[W-1] ? -weight_ff : weight_ff;
      sg2_ff.wn   <= weight_ff[W-1];
      sg2_ff.xn   <= dx1_ff[MW-1];
      sg2_ff.yn   <= dy1_ff[MW-1];
      sg2_ff.coin <= (dx1_ff == '0) && (dy1_ff == '0);

      sqx3_ff <= SW'(ux2_ff) * SW'(ux2_ff);
      sqy3_ff <= SW'(uy2_ff) * SW'(uy2_ff);
      k3_ff   <= k_in;
      ux3_ff  <= ux2_ff;
      uy3_ff  <= uy2_ff;
      uw3_ff  <= uw2_ff;
      sg3_ff  <= sg2_ff;

      ssum4_ff <= sqx3_ff + sqy3_ff;
      ax4_ff   <= AW'(ux3_ff >> k3_ff);
      ay4_ff   <= AW'(uy3_ff >> k3_ff);
      ux4_ff   <= ux3_ff;
      uy4_ff   <= uy3_ff;
      uw4_ff   <= uw3_ff;
      sg4_ff   <= sg3_ff;

      axx5_ff <= PW'(ax4_ff) * PW'(ax4_ff);
      ayy5_ff <= PW'(ay4_ff) * PW'(ay4_ff);
      axy5_ff <= PW'(ax4_ff) * PW'(ay4_ff);
      gnx5_ff <= GNW'(uw4_ff) * GNW'(ux4_ff);
      gny5_ff <= GNW'(uw4_ff) * GNW'(uy4_ff);
      uw5_ff  <= uw4_ff;
      sg5_ff  <= sg4_ff;

      sp6_ff  <= (PW + 1)'(axx5_ff) + (PW + 1)'(ayy5_ff);
      axx6_ff <= axx5_ff;
      ayy6_ff <= ayy5_ff;
      axy6_ff <= axy5_ff;
      uw6_ff  <= uw5_ff;
      sg6_ff  <= sg5_ff;

      // hess_xx weighs the y product, hess_yy the x product.
      plxx7_ff <= (W + AW)'(uw6_ff) * (W + AW)'(ayy6_ff[AW-1:0]);
      phxx7_ff <= (W + AW)'(uw6_ff) * (W + AW)'(ayy6_ff[PW-1:AW]);
      plyy7_ff <= (W + AW)'(uw6_ff) * (W + AW)'(axx6_ff[AW-1:0]);
      phyy7_ff <= (W + AW)'(uw6_ff) * (W + AW)'(axx6_ff[PW-1:AW]);
      plxy7_ff <= (W + AW)'(uw6_ff) * (W + AW)'(axy6_ff[AW-1:0]);
      phxy7_ff <= (W + AW)'(uw6_ff) * (W + AW)'(axy6_ff[PW-1:AW]);
      sp7_ff   <= sp6_ff;
      uw7_ff   <= uw6_ff;
      sg7_ff   <= sg6_ff;

      nxx8_ff <= (NQW'(phxx7_ff) << AW) + NQW'(plxx7_ff);
      nyy8_ff <= (NQW'(phyy7_ff) << AW) + NQW'(plyy7_ff);
      nxy8_ff <= (NQW'(phxy7_ff) << AW) + NQW'(plxy7_ff);
      sp8_ff  <= sp7_ff;
      uw8_ff  <= uw7_ff;
      sg8_ff  <= sg7_ff;

      gnx_dly_ff[0] <= gnx5_ff;
      gny_dly_ff[0] <= gny5_ff;
      for (int i = 1; i < GN_DLY; i++) begin
         gnx_dly_ff[i] <= gnx_dly_ff[i-1];
         gny_dly_ff[i] <= gny_dly_ff[i-1];
      end
      uw_dly_ff[0] <= uw8_ff;
      for (int i = 1; i < UW_DLY; i++) begin
         uw_dly_ff[i] <= uw_dly_ff[i-1];
      end
      sg_dly_ff[0] <= sg8_ff;
      for (int i = 1; i < FL_DLY; i++) begin
         sg_dly_ff[i] <= sg_dly_ff[i-1];
      end
      d_dly_ff[0] <= root_w;
      d_dly_ff[1] <= d_dly_ff[0];
      d_dly_ff[2] <= d_dly_ff[1];
      cp_dly_ff[0] <= CW'(uw_dly_ff[UW_DLY-1]) * CW'(d_dly_ff[2]);
      for (int i = 1; i < CP_DLY; i++) begin
         cp_dly_ff[i] <= cp_dly_ff[i-1];
      end
   end

   wdgh_sqrt #(.RW(MW)) u_sqrt (
      .clock    (clock),
      .radicand (ssum4_ff),
      .root     (root_w)
   );

   wdgh_div #(.NW(NQW), .DW(PW + 1), .QB(W)) u_div_qxx (
      .clock (clock), .num (nxx8_ff), .den (sp8_ff), .quo (qxx_w), .ovf ()
   );
   wdgh_div #(.NW(NQW), .DW(PW + 1), .QB(W)) u_div_qyy (
      .clock (clock), .num (nyy8_ff), .den (sp8_ff), .quo (qyy_w), .ovf ()
   );
   wdgh_div #(.NW(NQW), .DW(PW + 1), .QB(W)) u_div_qxy (
      .clock (clock), .num (nxy8_ff), .den (sp8_ff), .quo (qxy_w), .ovf ()
   );

   wdgh_div #(.NW(GNW), .DW(MW), .QB(W)) u_div_gx (
      .clock (clock), .num (gnx_dly_ff[GN_DLY-1]), .den (d_dly_ff[2]),
      .quo (gqx_w), .ovf (gx_ovf_w)
   );
   wdgh_div #(.NW(GNW), .DW(MW), .QB(W)) u_div_gy (
      .clock (clock), .num (gny_dly_ff[GN_DLY-1]), .den (d_dly_ff[2]),
      .quo (gqy_w), .ovf (gy_ovf_w)
   );
   wdgh_div #(.NW(HNW), .DW(MW), .QB(W)) u_div_hxx (
      .clock (clock), .num ({qxx_w, F'(0)}), .den (d_dly_ff[2]),
      .quo (hxx_w), .ovf (hxx_ovf_w)
   );
   wdgh_div #(.NW(HNW), .DW(MW), .QB(W)) u_div_hyy (
      .clock (clock), .num ({qyy_w, F'(0)}), .den (d_dly_ff[2]),
      .quo (hyy_w), .ovf (hyy_ovf_w)
   );
   wdgh_div #(.NW(HNW), .DW(MW), .QB(W)) u_div_hxy (
      .clock (clock), .num ({qxy_w, F'(0)}), .den (d_dly_ff[2]),
      .quo (hxy_w), .ovf (hxy_ovf_w)
   );

   always_comb begin
      sg_end_w = sg_dly_ff[FL_DLY-1];
      c_cost_w = clip_fn(cp_dly_ff[CP_DLY-1] >> F, sg_end_w.wn, 1'b0);
      c_gx_w   = clip_fn(CW'(gqx_w), sg_end_w.wn ^ sg_end_w.xn, gx_ovf_w);
      c_gy_w   = clip_fn(CW'(gqy_w), sg_end_w.wn ^ sg_end_w.yn, gy_ovf_w);
      c_hxx_w  = clip_fn(CW'(hxx_w), sg_end_w.wn, hxx_ovf_w);
      c_hyy_w  = clip_fn(CW'(hyy_w), sg_end_w.wn, hyy_ovf_w);
      c_hxy_w  = clip_fn(CW'(hxy_w), !(sg_end_w.wn ^ sg_end_w.xn ^ sg_end_w.yn), hxy_ovf_w);
   end

   always_ff @(posedge clock) begin
      if (sg_end_w.coin) begin
         rsp_cost_ff <= '0;
         rsp_gx_ff   <= '0;
         rsp_gy_ff   <= '0;
         rsp_hxx_ff  <= '0;
         rsp_hyy_ff  <= '0;
         rsp_hxy_ff  <= '0;
         rsp_sat_ff  <= 1'b0;
      end else begin
         rsp_cost_ff <= c_cost_w[W-1:0];
         rsp_gx_ff   <= c_gx_w[W-1:0];
         rsp_gy_ff   <= c_gy_w[W-1:0];
         rsp_hxx_ff  <= c_hxx_w[W-1:0];
         rsp_hyy_ff  <= c_hyy_w[W-1:0];
         rsp_hxy_ff  <= c_hxy_w[W-1:0];
         rsp_sat_ff  <= c_cost_w[W] | c_gx_w[W] | c_gy_w[W] | c_hxx_w[W] | c_hyy_w[W]
                        | c_hxy_w[W];
      end
      rsp_coin_ff <= sg_end_w.coin;
   end

   assign rsp_valid      = vld_ff[LAT-1];
   assign rsp_cost_value = rsp_cost_ff;
   assign rsp_grad_x     = rsp_gx_ff;
   assign rsp_grad_y     = rsp_gy_ff;
   assign rsp_hess_xx    = rsp_hxx_ff;
   assign rsp_hess_yy    = rsp_hyy_ff;
   assign rsp_hess_xy    = rsp_hxy_ff;
   assign rsp_coincident = rsp_coin_ff;
   assign rsp_saturated  = rsp_sat_ff;

   `WDGH_ASSERT_DLY(a_fixed_latency, start && !busy, LAT, rsp_valid, "result beat missing")
   `WDGH_ASSERT_IMP(a_coincident_zero, rsp_valid && rsp_coincident, !rsp_saturated && rsp_cost_value == '0 && rsp_grad_x == '0 && rsp_hess_xy == '0, "coincident beat not cleared")
   `WDGH_ASSERT_IMP(a_diag_sign, rsp_valid && rsp_hess_xx != '0 && rsp_hess_yy != '0, rsp_hess_xx[W-1] == rsp_hess_yy[W-1], "Hessian diagonal signs differ")

endmodule
